>>> rtl/acps_pkg.sv
// ----------------------------------------------------------------------------
// acps_pkg
// Shared widths, register codes, defaults and the sequencer state type of the
// autocorrelation period search.
// ----------------------------------------------------------------------------
`default_nettype none

package acps_pkg;

   // payload widths
   localparam int SAMPLE_W = 16;
   localparam int LAG_W    = 12;
   localparam int SCORE_W  = 47;
   localparam int PROD_W   = 2 * SAMPLE_W;

   // largest score that fits the result field
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // storage defaults
   localparam int DEF_MAX_SAMPLES = 16384;
   localparam int DEF_MAX_LAG     = 4095;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = LAG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LAG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LAG = 1'b1;
   localparam logic [LAG_W-1:0] MIN_LAG_RESET = 12'd50;
   localparam logic [LAG_W-1:0] MAX_LAG_RESET = 12'd1000;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_LAG,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/autocorrelation_period_search.sv
// ----------------------------------------------------------------------------
// autocorrelation_period_search
// Collects a record of audio samples and finds the lag with the strongest
// positive autocorrelation.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into the sample memory until a transfer
// with req_last set arrives; that sample is stored too and the search starts.
// Input stalls for the whole search. Each lag L from min_lag to max_lag
// (capped at MAX_LAG) is scored when L < N, N being the number of stored
// samples, by the single multiply-accumulate fed from the two read ports of
// the sample memory, one product per cycle; a lag of N or more gives an empty sum.
// The result sits in an output register and a new record is taken while it
// waits; a second search holds its result until the first one is
// transferred. Samples past MAX_SAMPLES are dropped and flagged in
// rsp_overflow. Scores above 2^47 - 1 are reported saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module autocorrelation_period_search #(
   parameter int MAX_SAMPLES = acps_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_LAG     = acps_pkg::DEF_MAX_LAG
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // sample input
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [acps_pkg::SAMPLE_W-1:0]   req_sample,
   input  wire logic                                   req_last,
   // result output
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [acps_pkg::LAG_W-1:0]                  rsp_best_lag,
   output logic [acps_pkg::SCORE_W-1:0]                rsp_best_score,
   output logic                                        rsp_overflow,
   // register writes
   input  wire logic                                   csr_we,
   input  wire logic [acps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [acps_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int LAGC_W  = acps_pkg::LAG_W + 1;
   localparam int CMP_W   = (CNT_W > LAGC_W) ? CNT_W : LAGC_W;
   localparam int ACC_W   = acps_pkg::PROD_W + ADDR_W;
   localparam int WIDE_W  = (ACC_W > acps_pkg::SCORE_W + 1) ? ACC_W : acps_pkg::SCORE_W + 1;
   localparam int LAG_TOP = (MAX_LAG > 4095) ? 4095 : MAX_LAG;

   // control and config registers
   acps_pkg::state_type state_ff, state_in;
   logic [acps_pkg::LAG_W-1:0] min_lag_ff, max_lag_ff;
   logic [CNT_W-1:0]           count_ff;
   logic                       overflow_ff;
   logic [LAGC_W-1:0]          lag_ff;
   logic [ADDR_W-1:0]          idx_ff;
   logic [CNT_W-1:0]           len_ff;
   logic                       rd_vld_ff, prod_vld_ff;
   logic signed [acps_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, best_ff;
   logic [acps_pkg::LAG_W-1:0] best_lag_ff;
   logic                       rsp_valid_ff;
   logic [acps_pkg::LAG_W-1:0] rsp_lag_ff;
   logic [acps_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                       rsp_ovf_ff;

   // sequencer strobes
   logic issue, lag_start, lag_next, best_init, best_upd, rsp_load;

   logic req_xfer, rsp_xfer, room;
   logic [acps_pkg::LAG_W-1:0] top_lag;
   logic [CMP_W-1:0] lag_ext, top_ext, count_ext;
   logic [ADDR_W-1:0] addr_b;
   logic signed [acps_pkg::SAMPLE_W-1:0] rd_data_a, rd_data_b;
   logic [WIDE_W-1:0] best_wide;
   logic [acps_pkg::SCORE_W-1:0] score_sat;

   // handshakes
   assign req_stall = (state_ff != acps_pkg::ST_LOAD);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign room      = (count_ff < CNT_W'(MAX_SAMPLES));

   // lag range and widened operands
   assign top_lag   = (max_lag_ff > acps_pkg::LAG_W'(LAG_TOP)) ?
                      acps_pkg::LAG_W'(LAG_TOP) : max_lag_ff;
   assign lag_ext   = CMP_W'(lag_ff);
   assign top_ext   = CMP_W'(top_lag);
   assign count_ext = CMP_W'(count_ff);
   assign addr_b    = ADDR_W'(CMP_W'(idx_ff) + lag_ext);

   // saturate the reported score
   assign best_wide = WIDE_W'($unsigned(best_ff));
   assign score_sat = (best_wide > WIDE_W'(acps_pkg::SCORE_MAX)) ?
                      acps_pkg::SCORE_MAX : best_wide[acps_pkg::SCORE_W-1:0];

   // sample memory
   acps_sample_mem #(
      .DEPTH  (MAX_SAMPLES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (req_xfer && room),
      .wr_addr   (count_ff[ADDR_W-1:0]),
      .wr_data   (req_sample),
      .rd_addr_a (idx_ff),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acps_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      issue     = 1'b0;
      lag_start = 1'b0;
      lag_next  = 1'b0;
      best_init = 1'b0;
      best_upd  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         acps_pkg::ST_LOAD: begin
            if (req_xfer && req_last) begin
               state_in = acps_pkg::ST_SETUP;
            end
         end
         acps_pkg::ST_SETUP: begin
            best_init = 1'b1;
            state_in  = acps_pkg::ST_LAG;
         end
         acps_pkg::ST_LAG: begin
            priority if (lag_ext > top_ext) begin
               state_in = acps_pkg::ST_DONE;
            end else if (lag_ext >= count_ext) begin
               // lag past the data gives an empty sum
               lag_next = 1'b1;
            end else begin
               lag_start = 1'b1;
               state_in  = acps_pkg::ST_MAC;
            end
         end
         acps_pkg::ST_MAC: begin
            issue = 1'b1;
            if (CNT_W'(idx_ff) + CNT_W'(1) == len_ff) begin
               state_in = acps_pkg::ST_DRAIN;
            end
         end
         acps_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               lag_next = 1'b1;
               best_upd = (acc_ff > best_ff);
               state_in = acps_pkg::ST_LAG;
            end
         end
         acps_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = acps_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = acps_pkg::ST_LOAD;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_lag_ff <= acps_pkg::MIN_LAG_RESET;
         max_lag_ff <= acps_pkg::MAX_LAG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            acps_pkg::CSR_MIN_LAG: min_lag_ff <= csr_wdata;
            acps_pkg::CSR_MAX_LAG: max_lag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // record fill count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (rsp_load) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (req_xfer) begin
         if (room) begin
            count_ff <= count_ff + CNT_W'(1);
         end else begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // lag and sample index counters
   always_ff @(posedge clock) begin
      if (best_init) begin
         lag_ff <= LAGC_W'(min_lag_ff);
      end else if (lag_next) begin
         lag_ff <= lag_ff + LAGC_W'(1);
      end
      if (lag_start) begin
         idx_ff <= '0;
         len_ff <= CNT_W'(count_ext - lag_ext);
      end else if (issue) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
   end

   // multiply-accumulate pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // product and accumulator
   always_ff @(posedge clock) begin
      prod_ff <= acps_pkg::PROD_W'(rd_data_a) * acps_pkg::PROD_W'(rd_data_b);
      if (lag_start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // best lag so far
   always_ff @(posedge clock) begin
      if (best_init) begin
         best_ff     <= '0;
         best_lag_ff <= min_lag_ff;
      end else if (best_upd) begin
         best_ff     <= acc_ff;
         best_lag_ff <= lag_ff[acps_pkg::LAG_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_lag_ff   <= best_lag_ff;
         rsp_score_ff <= score_sat;
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_lag   = rsp_lag_ff;
   assign rsp_best_score = rsp_score_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> rtl/acps_sample_mem.sv
// ----------------------------------------------------------------------------
// acps_sample_mem
// Sample memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module acps_sample_mem #(
   parameter int DEPTH  = acps_pkg::DEF_MAX_SAMPLES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [ADDR_W-1:0]                    wr_addr,
   input  wire logic signed [acps_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]                    rd_addr_a,
   input  wire logic [ADDR_W-1:0]                    rd_addr_b,
   output logic signed [acps_pkg::SAMPLE_W-1:0]      rd_data_a,
   output logic signed [acps_pkg::SAMPLE_W-1:0]      rd_data_b
);

   logic [acps_pkg::SAMPLE_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire
